FILE: rtl/cgcg_pkg.sv
// Shared types, widths and codes for the color gradient cell generator.
// Depends on nothing; every rtl file imports it.
package cgcg_pkg;

    // Payload field widths
    localparam int ColW  = 10;
    localparam int RowW  = 11;
    localparam int OrgW  = 10;
    localparam int ScrW  = 11;
    localparam int RgbW  = 24;
    localparam int ChW   = 8;

    // Geometry and arithmetic widths
    localparam int WidW  = 11;            // fill width register
    localparam int HgtW  = 12;            // fill height register
    localparam int DenW  = WidW + HgtW;   // dw * dh
    localparam int D14W  = DenW + 14;     // dw * dh * 16384
    localparam int NumW  = 52;            // signed numerator, all modes
    localparam int AngW  = 16;            // cosine / sine registers

    // Configuration port
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 24;

    // Pipeline depths
    localparam int DivLat  = 10;          // rounding divider, prep + saturate + 8 bits
    localparam int QDepth  = 2;           // front to back queue entries

    typedef enum logic [CfgIdxW-1:0] {
        CFG_FILL_MODE   = 3'd0,
        CFG_COLOR_A     = 3'd1,
        CFG_COLOR_B     = 3'd2,
        CFG_COLOR_C     = 3'd3,
        CFG_FILL_WIDTH  = 3'd4,
        CFG_FILL_HEIGHT = 3'd5,
        CFG_ANGLE_COS   = 3'd6,
        CFG_ANGLE_SIN   = 3'd7
    } t_cfg_idx;

    // Fill mode codes; the unused code behaves as corner mode
    localparam logic [1:0] MODE_CORNER = 2'd0;
    localparam logic [1:0] MODE_EDGE   = 2'd1;
    localparam logic [1:0] MODE_ANGLED = 2'd2;

    typedef struct packed {
        logic [ColW-1:0] column;
        logic [RowW-1:0] pixel_row;
        logic [OrgW-1:0] origin_row;
        logic [OrgW-1:0] origin_col;
    } t_req;

    typedef struct packed {
        logic [ScrW-1:0] screen_row;
        logic [ScrW-1:0] screen_col;
        logic [RgbW-1:0] top_color;
        logic [RgbW-1:0] bottom_color;
        logic            inside_res;
    } t_res;

    // Classified request as it travels through the queue
    typedef struct packed {
        logic [ColW-1:0] column;
        logic [RowW-1:0] pixel_row;
        logic [ScrW-1:0] screen_row;
        logic [ScrW-1:0] screen_col;
        logic            in_fill;
    } t_job;

    // Configuration and derived geometry handed to front and back
    typedef struct packed {
        logic [1:0]             mode;
        logic [RgbW-1:0]        color_a;
        logic [RgbW-1:0]        color_b;
        logic [RgbW-1:0]        color_c;
        logic [WidW-1:0]        w;
        logic [HgtW-1:0]        h;
        logic [WidW-1:0]        dw;
        logic [HgtW-1:0]        dh;
        logic [DenW-1:0]        d;
        logic signed [AngW-1:0] cosine;
        logic signed [AngW-1:0] sine;
    } t_geom;

    // Channel k of a packed color: 0 red, 1 green, 2 blue
    function automatic logic [ChW-1:0] chan_of(input logic [RgbW-1:0] c, input int k);
        return c[(2 - k) * ChW +: ChW];
    endfunction

endpackage

FILE: rtl/color_gradient_cell_generator.sv
// Top level of the color gradient cell generator: configuration registers,
// derived geometry, front stage, queue and back stage. Depends on cgcg_pkg.
//
// One cell request is taken per clock (start while busy is low) and yields
// exactly one result beat, marked by o_res_valid, once the request has passed
// the front classify register, the queue and the back pipeline, which holds
// the bit-per-stage rounding dividers. Results come out in request order at one
// per clock; the receiver cannot hold them off, and busy rises only if the back
// pipeline could not drain the queue, which in normal use it always does. Write
// configuration only while no request is in flight.
module color_gradient_cell_generator
    import cgcg_pkg::*;
#(
    parameter int MAX_COLUMNS    = 1024,
    parameter int MAX_PIXEL_ROWS = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  t_req               i_req,
    output logic               o_res_valid,
    output t_res               o_res,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CfgDatW-1:0] i_cfg_data
);

    logic [1:0]             r_fill_mode;
    logic [RgbW-1:0]        r_color_a;
    logic [RgbW-1:0]        r_color_b;
    logic [RgbW-1:0]        r_color_c;
    logic [WidW-1:0]        r_fill_width;
    logic [HgtW-1:0]        r_fill_height;
    logic signed [AngW-1:0] r_angle_cos;
    logic signed [AngW-1:0] r_angle_sin;

    logic [WidW-1:0] r_w, n_w, r_dw, n_dw;
    logic [HgtW-1:0] r_h, n_h, r_dh, n_dh;
    logic [DenW-1:0] r_d;

    t_geom geom;
    logic  cfg_we;
    logic  q_full, q_empty, push;
    t_job  front_job, q_job;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_mode   <= MODE_CORNER;
            r_color_a     <= '0;
            r_color_b     <= '0;
            r_color_c     <= '0;
            r_fill_width  <= WidW'(1);
            r_fill_height <= HgtW'(2);
            r_angle_cos   <= AngW'(16384);
            r_angle_sin   <= '0;
        end else if (cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FILL_MODE:   r_fill_mode   <= i_cfg_data[1:0];
                CFG_COLOR_A:     r_color_a     <= i_cfg_data[RgbW-1:0];
                CFG_COLOR_B:     r_color_b     <= i_cfg_data[RgbW-1:0];
                CFG_COLOR_C:     r_color_c     <= i_cfg_data[RgbW-1:0];
                CFG_FILL_WIDTH:  r_fill_width  <= i_cfg_data[WidW-1:0];
                CFG_FILL_HEIGHT: r_fill_height <= i_cfg_data[HgtW-1:0];
                CFG_ANGLE_COS:   r_angle_cos   <= $signed(i_cfg_data[AngW-1:0]);
                CFG_ANGLE_SIN:   r_angle_sin   <= $signed(i_cfg_data[AngW-1:0]);
            endcase
        end
    end

    // Saturated size and divisors
    always_comb begin
        n_w  = (int'(r_fill_width) > MAX_COLUMNS) ? WidW'(MAX_COLUMNS) : r_fill_width;
        n_h  = (int'(r_fill_height) > MAX_PIXEL_ROWS) ? HgtW'(MAX_PIXEL_ROWS)
                                                      : r_fill_height;
        n_dw = (n_w > WidW'(1)) ? n_w - WidW'(1) : WidW'(1);
        n_dh = (n_h > HgtW'(1)) ? n_h - HgtW'(1) : HgtW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w  <= WidW'(1);
            r_h  <= HgtW'(2);
            r_dw <= WidW'(1);
            r_dh <= HgtW'(1);
            r_d  <= DenW'(1);
        end else begin
            r_w  <= n_w;
            r_h  <= n_h;
            r_dw <= n_dw;
            r_dh <= n_dh;
            r_d  <= DenW'(n_dw) * DenW'(n_dh);
        end
    end

    always_comb begin
        geom.mode    = r_fill_mode;
        geom.color_a = r_color_a;
        geom.color_b = r_color_b;
        geom.color_c = r_color_c;
        geom.w       = r_w;
        geom.h       = r_h;
        geom.dw      = r_dw;
        geom.dh      = r_dh;
        geom.d       = r_d;
        geom.cosine  = r_angle_cos;
        geom.sine    = r_angle_sin;
    end

    cgcg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .i_geom  (geom),
        .i_full  (q_full),
        .o_busy  (o_busy),
        .o_push  (push),
        .o_job   (front_job)
    );

    cgcg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (!q_empty),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    cgcg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (!q_empty),
        .i_job   (q_job),
        .i_geom  (geom),
        .o_vld   (o_res_valid),
        .o_res   (o_res)
    );

endmodule

FILE: rtl/cgcg_front.sv
// Front stage: takes a request beat, classifies it (screen position, inside flag)
// and pushes it to the queue. Depends on cgcg_pkg.
module cgcg_front
    import cgcg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_req  i_req,
    input  t_geom i_geom,
    input  logic  i_full,
    output logic  o_busy,
    output logic  o_push,
    output t_job  o_job
);

    logic r_vld;
    logic n_vld;
    t_req r_req;
    logic accept;

    assign o_busy = r_vld && i_full;
    assign accept = i_start && !o_busy;
    assign o_push = r_vld && !i_full;

    // Holding register valid
    always_comb begin
        n_vld = r_vld;
        if (accept) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
    end

    // Classification: screen position and fill membership
    always_comb begin
        o_job.column     = r_req.column;
        o_job.pixel_row  = r_req.pixel_row;
        o_job.screen_row = ScrW'(r_req.origin_row) + ScrW'(r_req.pixel_row >> 1);
        o_job.screen_col = ScrW'(r_req.origin_col) + ScrW'(r_req.column);
        o_job.in_fill    = (WidW'(r_req.column) < i_geom.w) &&
                           ((HgtW'(r_req.pixel_row) + HgtW'(1)) < i_geom.h);
    end

endmodule

FILE: rtl/cgcg_queue.sv
// Two-entry queue between the front and back stages.
// Depends on cgcg_pkg for the job type and depth.
module cgcg_queue
    import cgcg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    localparam int CntW = $clog2(QDepth + 1);
    localparam int PtrW = $clog2(QDepth);

    t_job            r_mem [QDepth];
    logic [PtrW-1:0] r_wptr;
    logic [PtrW-1:0] r_rptr;
    logic [CntW-1:0] r_cnt;
    logic            do_pop;

    assign o_full  = (r_cnt == CntW'(QDepth));
    assign o_empty = (r_cnt == '0);
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PtrW'(QDepth - 1)) ? '0 : r_wptr + PtrW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PtrW'(QDepth - 1)) ? '0 : r_rptr + PtrW'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue pushed while full");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(QDepth))
        else $error("queue count out of range");

endmodule

FILE: rtl/cgcg_rdiv.sv
// Pipelined rounding divider: round(n/d) half away from zero, clamped to 0..255.
// One quotient bit per stage. Depends on cgcg_pkg.
module cgcg_rdiv
    import cgcg_pkg::*;
(
    input  logic                   i_clk,
    input  logic signed [NumW-1:0] i_num,
    input  logic [D14W-1:0]        i_den,
    output logic [ChW-1:0]         o_level
);

    localparam int RemW = NumW + 2;
    localparam int DvW  = D14W + 1;
    localparam int NBit = ChW;

    // Prep stage: 2n + d over 2d
    logic            r_a_neg;
    logic [RemW-1:0] r_a_num;
    logic [DvW-1:0]  r_a_den;

    // Bit stages; index 0 is the saturation stage
    logic            r_neg [NBit+1];
    logic            r_sat [NBit+1];
    logic [RemW-1:0] r_rem [NBit+1];
    logic [DvW-1:0]  r_den [NBit+1];
    logic [ChW-1:0]  r_q   [NBit+1];

    logic [RemW-1:0] n_sub [NBit+1];
    logic            n_ge  [NBit+1];

    always_ff @(posedge i_clk) begin
        r_a_neg <= i_num[NumW-1];
        r_a_num <= RemW'({i_num, 1'b0}) + RemW'(i_den);
        r_a_den <= {i_den, 1'b0};
    end

    // Quotient above 255 saturates
    always_ff @(posedge i_clk) begin
        r_neg[0] <= r_a_neg;
        r_sat[0] <= r_a_num >= (RemW'(r_a_den) << NBit);
        r_rem[0] <= r_a_num;
        r_den[0] <= r_a_den;
        r_q[0]   <= '0;
    end

    // Trial subtract per stage
    always_comb begin
        n_sub[0] = '0;
        n_ge[0]  = 1'b0;
        for (int i = 1; i <= NBit; i++) begin
            n_sub[i] = RemW'(r_den[i-1]) << (NBit - i);
            n_ge[i]  = r_rem[i-1] >= n_sub[i];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 1; i <= NBit; i++) begin
            r_neg[i] <= r_neg[i-1];
            r_sat[i] <= r_sat[i-1];
            r_den[i] <= r_den[i-1];
            r_rem[i] <= n_ge[i] ? r_rem[i-1] - n_sub[i] : r_rem[i-1];
            r_q[i]   <= r_q[i-1] | (n_ge[i] ? (ChW'(1) << (NBit - i)) : '0);
        end
    end

    assign o_level = r_neg[NBit] ? '0 : (r_sat[NBit] ? '1 : r_q[NBit]);

endmodule

FILE: rtl/cgcg_back.sv
// Back stage: per-channel numerator pipeline for both half pixels and six
// rounding dividers, then the result register. Depends on cgcg_pkg, cgcg_rdiv.
module cgcg_back
    import cgcg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_job  i_job,
    input  t_geom i_geom,
    output logic  o_vld,
    output t_res  o_res
);

    localparam int PW   = ColW + HgtW;        // x * dh
    localparam int QW   = HgtW + WidW;        // y * dw
    localparam int TyW  = HgtW + 1;           // dh - y
    localparam int M1W  = ChW + DenW;         // a * d
    localparam int M2W  = ChW + 1 + PW + 1;   // (b-a) * x*dh
    localparam int M3W  = ChW + 1 + QW + 1;   // (c-a) * y*dw
    localparam int EW   = 20;                 // a*dw + (b-a)*x
    localparam int CqW  = ChW + QW;           // c * y*dw
    localparam int PcW  = PW + 1 + AngW;
    localparam int QsW  = QW + 1 + AngW;
    localparam int TW   = QsW + 1;
    localparam int Lat  = 4 + DivLat;         // to the last divider stage
    localparam int BackLat = Lat + 1;

    logic r_vld [1:Lat];
    t_job r_job [1:Lat];
    logic r_out_vld;
    t_res r_out;

    // Stage 1: position products
    logic [ColW-1:0]       r1_x;
    logic [PW-1:0]         r1_p;
    logic [QW-1:0]         r1_q  [2];
    logic signed [TyW-1:0] r1_ty [2];
    logic [HgtW-1:0]       yy    [2];

    // Stage 2: color products
    logic [M1W-1:0]        r2_m1 [3];
    logic signed [M2W-1:0] r2_m2 [3];
    logic signed [M3W-1:0] r2_m3 [3][2];
    logic signed [EW-1:0]  r2_e  [3];
    logic [CqW-1:0]        r2_cq [3][2];
    logic signed [PcW-1:0] r2_pc;
    logic signed [QsW-1:0] r2_qs [2];
    logic signed [TyW-1:0] r2_ty [2];

    // Stage 3 and 4: numerators
    logic signed [NumW-1:0] r3_n  [3][2];
    logic signed [TW-1:0]   r3_t  [2];
    logic [M1W-1:0]         r3_m1 [3];
    logic signed [NumW-1:0] r4_n  [3][2];
    logic [D14W-1:0]        r4_d;

    logic [ChW-1:0]         lvl   [3][2];
    logic signed [ChW:0]    ba    [3];
    logic signed [ChW:0]    ca    [3];
    logic                   is_edge;
    logic                   is_angled;

    assign is_edge   = (i_geom.mode == MODE_EDGE);
    assign is_angled = (i_geom.mode == MODE_ANGLED);
    assign yy[0]     = HgtW'(i_job.pixel_row);
    assign yy[1]     = HgtW'(i_job.pixel_row) + HgtW'(1);

    // Channel differences
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ba[k] = $signed({1'b0, chan_of(i_geom.color_b, k)})
                  - $signed({1'b0, chan_of(i_geom.color_a, k)});
            ca[k] = $signed({1'b0, chan_of(i_geom.color_c, k)})
                  - $signed({1'b0, chan_of(i_geom.color_a, k)});
        end
    end

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= Lat; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else begin
            r_vld[1] <= i_vld;
            for (int i = 2; i <= Lat; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_out_vld <= r_vld[Lat];
        end
    end

    // Job chain
    always_ff @(posedge i_clk) begin
        r_job[1] <= i_job;
        for (int i = 2; i <= Lat; i++) begin
            r_job[i] <= r_job[i-1];
        end
    end

    // Stage 1
    always_ff @(posedge i_clk) begin
        r1_x <= i_job.column;
        r1_p <= PW'(i_job.column) * PW'(i_geom.dh);
        for (int h = 0; h < 2; h++) begin
            r1_q[h]  <= QW'(yy[h]) * QW'(i_geom.dw);
            r1_ty[h] <= $signed({1'b0, i_geom.dh}) - $signed({1'b0, yy[h]});
        end
    end

    // Stage 2
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r2_m1[k] <= M1W'(chan_of(i_geom.color_a, k)) * M1W'(i_geom.d);
            r2_m2[k] <= M2W'(ba[k]) * M2W'($signed({1'b0, r1_p}));
            r2_e[k]  <= EW'($signed({1'b0, chan_of(i_geom.color_a, k)}))
                          * EW'($signed({1'b0, i_geom.dw}))
                      + EW'(ba[k]) * EW'($signed({1'b0, r1_x}));
            for (int h = 0; h < 2; h++) begin
                r2_m3[k][h] <= M3W'(ca[k]) * M3W'($signed({1'b0, r1_q[h]}));
                r2_cq[k][h] <= CqW'(chan_of(i_geom.color_c, k)) * CqW'(r1_q[h]);
            end
        end
        r2_pc <= PcW'($signed({1'b0, r1_p})) * PcW'(i_geom.cosine);
        for (int h = 0; h < 2; h++) begin
            r2_qs[h] <= QsW'($signed({1'b0, r1_q[h]})) * QsW'(i_geom.sine);
            r2_ty[h] <= r1_ty[h];
        end
    end

    // Stage 3: corner and edge numerators, angled projection
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r3_m1[k] <= r2_m1[k];
            for (int h = 0; h < 2; h++) begin
                if (is_edge) begin
                    r3_n[k][h] <= NumW'(r2_e[k]) * NumW'(r2_ty[h])
                                + NumW'($signed({1'b0, r2_cq[k][h]}));
                end else begin
                    r3_n[k][h] <= NumW'($signed({1'b0, r2_m1[k]}))
                                + NumW'(r2_m2[k]) + NumW'(r2_m3[k][h]);
                end
            end
        end
        for (int h = 0; h < 2; h++) begin
            r3_t[h] <= TW'(r2_pc) - TW'(r2_qs[h]);
        end
    end

    // Stage 4: angled numerator, denominator
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            for (int h = 0; h < 2; h++) begin
                if (is_angled) begin
                    r4_n[k][h] <= (NumW'($signed({1'b0, r3_m1[k]})) <<< 14)
                                + NumW'(ba[k]) * NumW'(r3_t[h]);
                end else begin
                    r4_n[k][h] <= r3_n[k][h];
                end
            end
        end
        r4_d <= is_angled ? {i_geom.d, 14'b0} : D14W'(i_geom.d);
    end

    // Rounding dividers, one per channel and half pixel
    for (genvar gk = 0; gk < 3; gk++) begin : g_chan
        for (genvar gh = 0; gh < 2; gh++) begin : g_half
            cgcg_rdiv u_rdiv (
                .i_clk   (i_clk),
                .i_num   (r4_n[gk][gh]),
                .i_den   (r4_d),
                .o_level (lvl[gk][gh])
            );
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        r_out.screen_row   <= r_job[Lat].screen_row;
        r_out.screen_col   <= r_job[Lat].screen_col;
        r_out.inside_res   <= r_job[Lat].in_fill;
        r_out.top_color    <= {lvl[0][0], lvl[1][0], lvl[2][0]};
        r_out.bottom_color <= is_angled ? {lvl[0][0], lvl[1][0], lvl[2][0]}
                                        : {lvl[0][1], lvl[1][1], lvl[2][1]};
    end

    assign o_vld = r_out_vld;
    assign o_res = r_out;

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vld |-> ##BackLat o_vld)
        else $error("back stage result missing at fixed latency");

endmodule

FILE: verif/color_gradient_cell_generator_tb.sv
// Testbench for the color gradient cell generator: directed and random cell
// requests checked against a local per-channel gradient predictor.
// Depends on cgcg_pkg and rtl/color_gradient_cell_generator.sv.
`timescale 1ns / 1ps

module color_gradient_cell_generator_tb;
    import cgcg_pkg::*;

    localparam int MaxCols  = 1024;
    localparam int MaxRows  = 2048;
    localparam int Latency  = 17;
    localparam longint CycleLimit = 400000;
    localparam logic [1:0] ModeUnused = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    t_req               i_req;
    logic               o_res_valid;
    t_res               o_res;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index;
    logic [CfgDatW-1:0] i_cfg_data;

    // Local copy of the configuration registers
    logic [1:0]         shadow_mode;
    logic [RgbW-1:0]    shadow_a, shadow_b, shadow_c;
    logic [WidW-1:0]    shadow_w;
    logic [HgtW-1:0]    shadow_h;
    logic signed [15:0] shadow_cos, shadow_sin;

    t_res   cell_queue[$];
    int     fail_count;
    int     beats_checked;
    int     send_idle_pct;
    longint cycle_count;

    color_gradient_cell_generator dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Round half away from zero, clamp to a byte
    function automatic logic [7:0] round_to_byte(input longint n, input longint d);
        longint q;
        if (n >= 0) q = (2 * n + d) / (2 * d);
        else q = -((2 * (-n) + d) / (2 * d));
        if (q < 0) return 8'd0;
        if (q > 255) return 8'd255;
        return q[7:0];
    endfunction

    function automatic logic [RgbW-1:0] gradient_color(input longint x, input longint y,
                                                       input longint dw, input longint dh);
        logic [RgbW-1:0] rgb;
        longint a, b, c, n, d;
        rgb = '0;
        for (int k = 0; k < 3; k++) begin
            a = shadow_a[(2 - k) * 8 +: 8];
            b = shadow_b[(2 - k) * 8 +: 8];
            c = shadow_c[(2 - k) * 8 +: 8];
            d = dw * dh;
            if (shadow_mode == MODE_EDGE) begin
                n = (a * dw + (b - a) * x) * (dh - y) + c * dw * y;
            end else if (shadow_mode == MODE_ANGLED) begin
                n = a * d * 16384 + (b - a) * (x * dh * longint'(shadow_cos)
                    - y * dw * longint'(shadow_sin));
                d = d * 16384;
            end else begin
                n = a * d + (b - a) * x * dh + (c - a) * y * dw;
            end
            rgb[(2 - k) * 8 +: 8] = round_to_byte(n, d);
        end
        return rgb;
    endfunction

    function automatic t_res predict_cell(input t_req rq);
        t_res   r;
        longint w, h, dw, dh, x, y;
        w = shadow_w > MaxCols ? MaxCols : shadow_w;
        h = shadow_h > MaxRows ? MaxRows : shadow_h;
        dw = w > 1 ? w - 1 : 1;
        dh = h > 1 ? h - 1 : 1;
        x = rq.column;
        y = rq.pixel_row;
        r.screen_row   = ScrW'(rq.origin_row) + ScrW'(rq.pixel_row >> 1);
        r.screen_col   = ScrW'(rq.origin_col) + ScrW'(rq.column);
        r.top_color    = gradient_color(x, y, dw, dh);
        r.bottom_color = shadow_mode == MODE_ANGLED ? r.top_color
                                                    : gradient_color(x, y + 1, dw, dh);
        r.inside_res   = (x < w) && (y + 1 < h);
        return r;
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_valid) begin
            beats_checked++;
            if (cell_queue.size() == 0) begin
                $error("result beat with no request outstanding");
                fail_count++;
            end else begin
                want = cell_queue.pop_front();
                if (o_res.screen_row !== want.screen_row) begin
                    $error("screen_row exp %0d got %0d", want.screen_row, o_res.screen_row);
                    fail_count++;
                end
                if (o_res.screen_col !== want.screen_col) begin
                    $error("screen_col exp %0d got %0d", want.screen_col, o_res.screen_col);
                    fail_count++;
                end
                if (o_res.top_color !== want.top_color) begin
                    $error("top_color exp %06h got %06h", want.top_color, o_res.top_color);
                    fail_count++;
                end
                if (o_res.bottom_color !== want.bottom_color) begin
                    $error("bottom_color exp %06h got %06h", want.bottom_color,
                           o_res.bottom_color);
                    fail_count++;
                end
                if (o_res.inside_res !== want.inside_res) begin
                    $error("inside_res exp %0d got %0d", want.inside_res, o_res.inside_res);
                    fail_count++;
                end
            end
        end
    end

    // One request beat, with optional idle cycles before it; start stays high
    // after the beat so a following beat can go out in the next cycle
    task automatic send_cell(input t_req rq);
        while ($urandom_range(99) < send_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= rq;
        do @(posedge i_clk); while (o_busy);
        cell_queue.push_back(predict_cell(rq));
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        while (cell_queue.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CfgDatW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_FILL_MODE:   shadow_mode = val[1:0];
            CFG_COLOR_A:     shadow_a    = val;
            CFG_COLOR_B:     shadow_b    = val;
            CFG_COLOR_C:     shadow_c    = val;
            CFG_FILL_WIDTH:  shadow_w    = val[WidW-1:0];
            CFG_FILL_HEIGHT: shadow_h    = val[HgtW-1:0];
            CFG_ANGLE_COS:   shadow_cos  = val[15:0];
            CFG_ANGLE_SIN:   shadow_sin  = val[15:0];
            default: ;
        endcase
    endtask

    task automatic setup_fill(input logic [1:0] mode, input int w, input int h,
                              input int cs, input int sn);
        drain_results();
        write_reg(CFG_FILL_MODE, CfgDatW'(mode));
        write_reg(CFG_COLOR_A, CfgDatW'($urandom_range(24'hFFFFFF)));
        write_reg(CFG_COLOR_B, CfgDatW'($urandom_range(24'hFFFFFF)));
        write_reg(CFG_COLOR_C, CfgDatW'($urandom_range(24'hFFFFFF)));
        write_reg(CFG_FILL_WIDTH, CfgDatW'(w));
        write_reg(CFG_FILL_HEIGHT, CfgDatW'(h));
        write_reg(CFG_ANGLE_COS, CfgDatW'(cs));
        write_reg(CFG_ANGLE_SIN, CfgDatW'(sn));
    endtask

    function automatic t_req cell_in_fill();
        t_req rq;
        int   w, h;
        w = shadow_w > MaxCols ? MaxCols : (shadow_w == 0 ? 1 : shadow_w);
        h = shadow_h > MaxRows ? MaxRows : (shadow_h < 2 ? 2 : shadow_h);
        rq.column     = ColW'($urandom_range(w - 1));
        rq.pixel_row  = RowW'($urandom_range(h - 1)) & ~RowW'(1);
        rq.origin_row = OrgW'($urandom);
        rq.origin_col = OrgW'($urandom);
        return rq;
    endfunction

    // Field extremes and default registers
    task automatic test_reset_defaults();
        t_req rq;
        rq = '0;
        send_cell(rq);
        rq = '1;
        send_cell(rq);
        rq = '{column: 0, pixel_row: 1, origin_row: '1, origin_col: 0};
        send_cell(rq);
    endtask

    // Every mode, degenerate, oversized and clamping cases
    task automatic test_directed_modes();
        t_req rq;
        setup_fill(MODE_CORNER, 1024, 2048, 16384, 0);
        write_reg(CFG_COLOR_A, 24'h000000);
        write_reg(CFG_COLOR_B, 24'hFFFFFF);
        write_reg(CFG_COLOR_C, 24'hFFFFFF);  // corner sum exceeds 255, clamps
        rq = '{column: 1023, pixel_row: 2046, origin_row: 1023, origin_col: 1023};
        send_cell(rq);
        rq = '{column: 511, pixel_row: 1023, origin_row: 5, origin_col: 7};
        send_cell(rq);
        setup_fill(MODE_EDGE, 7, 9, 16384, 0);
        send_cell('{column: 6, pixel_row: 8, origin_row: 0, origin_col: 0});
        send_cell('{column: 7, pixel_row: 2, origin_row: 1, origin_col: 1});
        setup_fill(MODE_ANGLED, 5, 6, -16384, 16384);
        send_cell('{column: 4, pixel_row: 4, origin_row: 3, origin_col: 3});
        send_cell('{column: 0, pixel_row: 5, origin_row: 3, origin_col: 3});
        setup_fill(MODE_ANGLED, 3, 3, 11585, -11585);
        send_cell('{column: 2, pixel_row: 2, origin_row: 0, origin_col: 9});
        setup_fill(ModeUnused, 0, 0, 0, 0);  // unused mode, zero sizes
        send_cell('{column: 0, pixel_row: 0, origin_row: 0, origin_col: 0});
        send_cell('{column: 3, pixel_row: 3, origin_row: 0, origin_col: 0});
        setup_fill(MODE_EDGE, 2047, 4095, 16384, -16384);  // beyond the limits
        send_cell('{column: 1023, pixel_row: 2046, origin_row: 9, origin_col: 9});
        send_cell('{column: 1023, pixel_row: 2047, origin_row: 9, origin_col: 9});
    endtask

    // Random phases with random registers
    task automatic test_random_cells(input int idle_pct, input int n_cells);
        t_req rq;
        int   w, h;
        send_idle_pct = idle_pct;
        for (int p = 0; p < 10; p++) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(1, 40);
            h = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(1, 80);
            setup_fill(2'($urandom_range(3)), w, h,
                       int'($urandom_range(32768)) - 16384,
                       int'($urandom_range(32768)) - 16384);
            for (int i = 0; i < n_cells / 10; i++) begin
                if ($urandom_range(4) == 0) rq = t_req'({$urandom, 9'($urandom)});
                else rq = cell_in_fill();
                send_cell(rq);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FILL_MODE;
        i_cfg_data = '0;
        fail_count = 0;
        beats_checked = 0;
        send_idle_pct = 0;
        cycle_count = 0;
        shadow_mode = MODE_CORNER;
        shadow_a = '0;
        shadow_b = '0;
        shadow_c = '0;
        shadow_w = 1;
        shadow_h = 2;
        shadow_cos = 16384;
        shadow_sin = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_modes();
        test_random_cells(36, 500);
        test_random_cells(57, 500);
        test_random_cells(0, 500);
        drain_results();

        $display("Covered corner, edge, angled and unused modes; %0d result beats checked.",
                 beats_checked);
        if (fail_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
